### design/sfrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared types, constants and the CRC-16/ARC byte step for the stuffed frame
// receiver.
// ----------------------------------------------------------------------------
package sfrc_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0] FlagStart    = 8'hFE;
  localparam logic [7:0] FlagEnd      = 8'hFF;
  localparam logic [7:0] EscByte      = 8'hFD;
  localparam logic [7:0] EscMax       = 8'h02;
  localparam logic [7:0] VersionQuery = 8'h00;
  localparam logic [7:0] VersionReset = 8'h01;
  localparam logic [15:0] CrcPoly     = 16'hA001;

  localparam logic [2:0] StGood       = 3'd0;
  localparam logic [2:0] StBadCrc     = 3'd1;
  localparam logic [2:0] StBadEnd     = 3'd2;
  localparam logic [2:0] StBadStuff   = 3'd3;
  localparam logic [2:0] StBadVersion = 3'd4;
  localparam logic [2:0] StQuery      = 3'd5;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef struct packed {
    logic       is_start;
    logic       is_end;
    logic       is_esc;
    logic       esc_ok;
    logic [7:0] raw;
  } token_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {8'h00, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ CrcPoly) : (t >> 1);
    end
    return {8'h00, crc[15:8]} ^ t;
  endfunction

endpackage
`default_nettype wire

### design/sfrc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_if
// Valid/ready channels of the stuffed frame receiver: line bytes in, results
// out.
// ----------------------------------------------------------------------------
interface sfrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface sfrc_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] data_byte;
  logic       is_command;
  logic [2:0] frame_status;

  modport source(output valid, output out_kind, output data_byte, output is_command,
                 output frame_status, input ready);
  modport sink(input valid, input out_kind, input data_byte, input is_command,
               input frame_status, output ready);
endinterface
`default_nettype wire

### design/sfrc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_front
// Accepts line bytes and classifies them into flag, escape and data tokens.
// ----------------------------------------------------------------------------
module sfrc_front (
  sfrc_rx_if.sink          rx_i,
  input  wire logic        full_i,
  output sfrc_pkg::token_t token_o,
  output logic             push_o
);

  assign rx_i.ready = !full_i;
  assign push_o     = rx_i.valid && !full_i;

  always_comb begin
    token_o.raw      = rx_i.rx_byte;
    token_o.is_start = (rx_i.rx_byte == sfrc_pkg::FlagStart);
    token_o.is_end   = (rx_i.rx_byte == sfrc_pkg::FlagEnd);
    token_o.is_esc   = (rx_i.rx_byte == sfrc_pkg::EscByte);
    token_o.esc_ok   = (rx_i.rx_byte <= sfrc_pkg::EscMax);
  end

endmodule
`default_nettype wire

### design/sfrc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_queue
// Small token queue between the classifying front and the frame parser.
// ----------------------------------------------------------------------------
module sfrc_queue #(
  parameter int unsigned Depth = sfrc_pkg::FifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sfrc_pkg::token_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output sfrc_pkg::token_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sfrc_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == FullCnt)
    else $error("Queue lost a token while full.");
`endif

endmodule
`default_nettype wire

### design/sfrc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_back
// Frame parser: undoes escapes, checks version and CRC-16/ARC, streams the
// payload and reports one status per frame through an output register.
// ----------------------------------------------------------------------------
module sfrc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [7:0]       cfg_wdata_i,
  input  wire logic             tok_valid_i,
  input  wire sfrc_pkg::token_t tok_i,
  output logic                  pop_o,
  sfrc_res_if.source            res_o
);

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhVersion = 3'd1;
  localparam logic [2:0] PhSize    = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhCrcHi   = 3'd4;
  localparam logic [2:0] PhCrcLo   = 3'd5;
  localparam logic [2:0] PhEnd     = 3'd6;

  logic [7:0]  version_q;
  logic [2:0]  phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic        first_q, first_d;
  logic        ovalid_q, ovalid_d;
  logic        kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic        cmd_q, cmd_d;
  logic [2:0]  st_q, st_d;
  logic        emit;
  logic        proc;
  logic        in_frame;
  logic [7:0]  b;

  assign pop_o    = tok_valid_i && (!ovalid_q || res_o.ready);
  assign in_frame = (phase_q >= PhVersion) && (phase_q <= PhEnd);

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    crc_d    = crc_q;
    left_d   = left_q;
    crc_hi_d = crc_hi_q;
    first_d  = first_q;
    emit     = 1'b0;
    proc     = 1'b0;
    kind_d   = sfrc_pkg::KindStatus;
    data_d   = 8'h00;
    cmd_d    = 1'b0;
    st_d     = sfrc_pkg::StGood;
    b        = tok_i.raw;
    if (pop_o) begin
      priority if (tok_i.is_start) begin
        phase_d  = PhVersion;
        esc_d    = 1'b0;
        crc_d    = '0;
        left_d   = '0;
        crc_hi_d = '0;
        first_d  = 1'b0;
        emit     = in_frame;
        st_d     = sfrc_pkg::StBadEnd;
      end else if (!in_frame) begin
        phase_d = PhHunt;
      end else if (phase_q == PhEnd) begin
        phase_d = PhHunt;
        esc_d   = 1'b0;
        emit    = 1'b1;
        if (!tok_i.is_end) begin
          st_d = sfrc_pkg::StBadEnd;
        end else if (crc_q != '0) begin
          st_d = sfrc_pkg::StBadCrc;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (!tok_i.esc_ok) begin
          phase_d = PhHunt;
          emit    = 1'b1;
          st_d    = sfrc_pkg::StBadStuff;
        end else begin
          b    = sfrc_pkg::EscByte + tok_i.raw;
          proc = 1'b1;
        end
      end else if (tok_i.is_end) begin
        phase_d = PhHunt;
        emit    = 1'b1;
        st_d    = sfrc_pkg::StBadEnd;
      end else if (tok_i.is_esc) begin
        esc_d = 1'b1;
      end else begin
        proc = 1'b1;
      end

      if (proc) begin
        unique case (phase_q)
          PhVersion: begin
            if (b == sfrc_pkg::VersionQuery) begin
              phase_d = PhHunt;
              emit    = 1'b1;
              st_d    = sfrc_pkg::StQuery;
            end else if (b != version_q) begin
              phase_d = PhHunt;
              emit    = 1'b1;
              st_d    = sfrc_pkg::StBadVersion;
            end else begin
              crc_d   = sfrc_pkg::crc_step('0, b);
              phase_d = PhSize;
            end
          end
          PhSize: begin
            crc_d   = sfrc_pkg::crc_step(crc_q, b);
            left_d  = b;
            first_d = 1'b1;
            phase_d = (b == 8'h00) ? PhCrcHi : PhPayload;
          end
          PhPayload: begin
            crc_d   = sfrc_pkg::crc_step(crc_q, b);
            emit    = 1'b1;
            kind_d  = sfrc_pkg::KindPayload;
            data_d  = b;
            cmd_d   = first_q;
            first_d = 1'b0;
            left_d  = left_q - 1'b1;
            if (left_q == 8'h01) begin
              phase_d = PhCrcHi;
            end
          end
          PhCrcHi: begin
            crc_hi_d = b;
            phase_d  = PhCrcLo;
          end
          default: begin
            crc_d   = crc_q ^ {crc_hi_q, b};
            phase_d = PhEnd;
          end
        endcase
      end
    end

    if (pop_o) begin
      ovalid_d = emit;
    end else begin
      ovalid_d = ovalid_q && !res_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= sfrc_pkg::VersionReset;
      phase_q   <= PhHunt;
      esc_q     <= 1'b0;
      crc_q     <= '0;
      left_q    <= '0;
      crc_hi_q  <= '0;
      first_q   <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        version_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      crc_q    <= crc_d;
      left_q   <= left_d;
      crc_hi_q <= crc_hi_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      cmd_q  <= cmd_d;
      st_q   <= st_d;
    end
  end

  assign res_o.valid        = ovalid_q;
  assign res_o.out_kind     = kind_q;
  assign res_o.data_byte    = data_q;
  assign res_o.is_command   = cmd_q;
  assign res_o.frame_status = st_q;

`ifndef NO_ASSERTIONS
  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (phase_q == PhVersion || phase_q == PhSize || phase_q == PhPayload ||
               phase_q == PhCrcHi || phase_q == PhCrcLo))
    else $error("Escape pending outside the stuffed part of a frame.");
  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && tok_i.is_start |=> phase_q == PhVersion && !esc_q && crc_q == '0)
    else $error("Start flag did not restart the frame.");
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && kind_q == sfrc_pkg::KindStatus |-> data_q == 8'h00 && !cmd_q)
    else $error("Status transaction carries payload bits.");
  a_payload_only_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && emit && kind_d == sfrc_pkg::KindPayload |-> phase_q == PhPayload)
    else $error("Payload byte produced outside the payload phase.");
`endif

endmodule
`default_nettype wire

### design/stuffed_frame_receiver_crc16_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_core
// Receives byte-stuffed frames, streams their payload and reports a status.
// ----------------------------------------------------------------------------
// Line bytes enter on rx_i, one transaction per cycle when rx_i.ready is high.
// Results leave on res_o: a payload byte (out_kind 0, is_command on the first
// byte of a frame) or one frame status (out_kind 1). Bytes that produce no
// result, such as flags, escapes, header and CRC bytes, are consumed silently.
// The block sustains one byte per cycle while results are taken; the limit is
// the parser step, which holds the escape logic and one bytewise CRC-16/ARC
// update. A small token queue sits between the input classifier and the
// parser, and the result is held in an output register, so a new byte is taken
// while a result waits. When res_o.ready stays low with a result held, the
// parser stops, the queue fills and rx_i.ready falls once it is full. The
// user writes the accepted version through cfg_we_i and cfg_wdata_i only while
// the block is idle; the block does not enforce this. Reset makes the receiver
// hunt for a start flag, empties the queue and the output register and sets
// the accepted version to one.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc16_core #(
  parameter int unsigned FifoDepth = sfrc_pkg::FifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  sfrc_rx_if.sink         rx_i,
  sfrc_res_if.source      res_o
);

  sfrc_pkg::token_t push_tok, pop_tok;
  logic             push, full, tok_valid, pop;

  sfrc_front u_front (
    .rx_i    (rx_i),
    .full_i  (full),
    .token_o (push_tok),
    .push_o  (push)
  );

  sfrc_queue #(
    .Depth(FifoDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tok),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (tok_valid),
    .data_o      (pop_tok)
  );

  sfrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_valid_i (tok_valid),
    .tok_i       (pop_tok),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

### tb/sfrc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_frame_checker
// Watches both channels of the stuffed frame receiver, decodes the accepted
// line bytes on its own, and compares every result transaction with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module sfrc_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sfrc_rx_if         rx_mon,
  sfrc_res_if        res_mon,
  output int         pending_o,
  output int         fail_count_o
);
  import sfrc_pkg::*;

  typedef enum logic [2:0] {
    PhHunt, PhVersion, PhSize, PhPayload, PhCrcHi, PhCrcLo, PhEndFlag
  } parse_phase_e;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] data_byte;
    logic       is_command;
    logic [2:0] frame_status;
  } frame_result_t;

  logic [7:0]    version_reg;
  parse_phase_e  phase;
  logic          escape_pending;
  logic [15:0]   crc_residue;
  logic [7:0]    bytes_left;
  logic [7:0]    crc_high;
  logic          first_payload;
  frame_result_t expected_results_q[$];
  int            fail_count;

  function automatic logic [15:0] crc16_arc_update(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_status(input logic [2:0] st);
    expected_results_q.push_back('{KindStatus, 8'h00, 1'b0, st});
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic decode_line_byte(input logic [7:0] raw);
    logic [7:0] b;
    if (raw == FlagStart) begin
      if (phase != PhHunt) push_status(StBadEnd);
      phase = PhVersion;
      escape_pending = 1'b0;
      crc_residue = '0;
      bytes_left = '0;
      crc_high = '0;
      first_payload = 1'b0;
      return;
    end
    if (phase == PhHunt) return;
    if (phase == PhEndFlag) begin
      phase = PhHunt;
      escape_pending = 1'b0;
      if (raw != FlagEnd) begin
        push_status(StBadEnd);
      end else begin
        push_status((crc_residue == '0) ? StGood : StBadCrc);
      end
      return;
    end
    if (escape_pending) begin
      escape_pending = 1'b0;
      if (raw > EscMax) begin
        phase = PhHunt;
        push_status(StBadStuff);
        return;
      end
      b = EscByte + raw;
    end else if (raw == FlagEnd) begin
      phase = PhHunt;
      push_status(StBadEnd);
      return;
    end else if (raw == EscByte) begin
      escape_pending = 1'b1;
      return;
    end else begin
      b = raw;
    end

    case (phase)
      PhVersion: begin
        if (b == VersionQuery) begin
          phase = PhHunt;
          push_status(StQuery);
        end else if (b != version_reg) begin
          phase = PhHunt;
          push_status(StBadVersion);
        end else begin
          crc_residue = crc16_arc_update(16'h0000, b);
          phase = PhSize;
        end
      end
      PhSize: begin
        crc_residue = crc16_arc_update(crc_residue, b);
        bytes_left = b;
        first_payload = 1'b1;
        phase = (b == 8'h00) ? PhCrcHi : PhPayload;
      end
      PhPayload: begin
        crc_residue = crc16_arc_update(crc_residue, b);
        expected_results_q.push_back('{KindPayload, b, first_payload, 3'b000});
        first_payload = 1'b0;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) phase = PhCrcHi;
      end
      PhCrcHi: begin
        crc_high = b;
        phase = PhCrcLo;
      end
      default: begin
        crc_residue = crc_residue ^ {crc_high, b};
        phase = PhEndFlag;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      version_reg = VersionReset;
      phase = PhHunt;
      escape_pending = 1'b0;
      crc_residue = '0;
      bytes_left = '0;
      crc_high = '0;
      first_payload = 1'b0;
      expected_results_q.delete();
      fail_count = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) version_reg = cfg_wdata_i;
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.out_kind, res_mon.data_byte, res_mon.is_command,
                res_mon.frame_status};
        if (expected_results_q.size() == 0) begin
          $error("Unexpected result transaction: kind %0b, data 0x%0h, status %0d",
                 got.out_kind, got.data_byte, got.frame_status);
          fail_count++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("out_kind", 8'(want.out_kind), 8'(got.out_kind));
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("is_command", 8'(want.is_command), 8'(got.is_command));
          check_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
        end
      end
      if (rx_mon.valid && rx_mon.ready) decode_line_byte(rx_mon.rx_byte);
      pending_o <= expected_results_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives stuffed line bytes into the frame receiver: a few directed frames,
// then random well-formed and damaged frames under several accepted versions,
// with bursty input and a stalling result receiver. The checker module
// predicts and compares; this module only gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sfrc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  int         pending_results;
  int         fail_count;

  sfrc_rx_if  rx_bus ();
  sfrc_res_if res_bus ();

  logic [7:0] line_q[$];
  logic [7:0] body_q[$];
  logic [7:0] cur_version;
  logic [7:0] version_plan[5];
  int         burst_left;
  int         items_sent;

  always #10 clk_i = ~clk_i;

  stuffed_frame_receiver_crc16_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_bus),
    .res_o      (res_bus)
  );

  sfrc_frame_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_mon      (rx_bus),
    .res_mon     (res_bus),
    .pending_o   (pending_results),
    .fail_count_o(fail_count)
  );

  function automatic logic [7:0] pick_line_byte();
    case ($urandom_range(0, 7))
      0: return EscByte;
      1: return FlagStart;
      2: return FlagEnd;
      3: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_stuffed(input logic [7:0] b);
    if (b >= EscByte) begin
      line_q.push_back(EscByte);
      line_q.push_back(b - EscByte);
    end else begin
      line_q.push_back(b);
    end
  endtask

  task automatic add_frame(input logic [15:0] crc_flip);
    logic [15:0] crc;
    crc = '0;
    foreach (body_q[i]) crc = u_check.crc16_arc_update(crc, body_q[i]);
    crc = crc ^ crc_flip;
    line_q.push_back(FlagStart);
    foreach (body_q[i]) add_stuffed(body_q[i]);
    add_stuffed(crc[15:8]);
    add_stuffed(crc[7:0]);
    line_q.push_back(FlagEnd);
  endtask

  task automatic send_line_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        rx_bus.valid <= 1'b0;
        rx_bus.rx_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_bus.valid <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_line();
    while (line_q.size() > 0) send_line_byte(line_q.pop_front());
  endtask

  task automatic wait_idle();
    int ready_edges;
    ready_edges = 0;
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    while (ready_edges < 8) begin
      @(posedge clk_i);
      if (res_bus.ready) ready_edges++;
    end
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_version = v;
  endtask

  task automatic run_directed();
    line_q.push_back(EscByte);
    line_q.push_back(FlagEnd);
    line_q.push_back(FlagStart);
    line_q.push_back(VersionQuery);
    body_q.delete();
    body_q.push_back(VersionReset);
    body_q.push_back(8'h00);
    add_frame(16'h0000);
    body_q.delete();
    body_q.push_back(VersionReset);
    body_q.push_back(8'h01);
    body_q.push_back(FlagStart);
    add_frame(16'h0000);
    line_q.push_back(FlagStart);
    line_q.push_back(VersionReset);
    line_q.push_back(EscByte);
    line_q.push_back(8'h03);
    line_q.push_back(FlagStart);
    line_q.push_back(VersionReset);
    line_q.push_back(EscByte);
    line_q.push_back(FlagStart);
    line_q.push_back(8'h02);
    send_line();
  endtask

  task automatic add_random_frame();
    int         pick;
    int         size;
    int         pos;
    logic [7:0] version;
    logic [7:0] junk;
    pick = $urandom_range(0, 99);
    if (pick >= 96) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(pick_line_byte());
      return;
    end
    version = cur_version;
    if (pick >= 60 && pick < 66) begin
      version = VersionQuery;
    end else if (pick >= 66 && pick < 72) begin
      do version = 8'($urandom_range(0, 255));
      while (version == cur_version || version == VersionQuery);
    end
    size = ($urandom_range(0, 99) == 0) ? $urandom_range(20, 255) : $urandom_range(0, 8);
    body_q.delete();
    body_q.push_back(version);
    body_q.push_back(size[7:0]);
    repeat (size) body_q.push_back(pick_line_byte());
    add_frame((pick >= 72 && pick < 80) ? (16'h0001 << $urandom_range(0, 15)) : 16'h0000);
    if (pick >= 80 && pick < 86) begin
      do junk = pick_line_byte();
      while (junk == FlagEnd);
      line_q[line_q.size() - 1] = junk;
    end else if (pick >= 86 && pick < 91) begin
      pos = $urandom_range(1, line_q.size() - 1);
      do junk = pick_line_byte();
      while (junk <= EscMax);
      line_q.insert(pos, junk);
      line_q.insert(pos, EscByte);
    end else if (pick >= 91) begin
      pos = $urandom_range(1, line_q.size() - 2);
      while (line_q.size() > pos + 1) void'(line_q.pop_back());
      if ($urandom_range(0, 1) == 1) line_q.push_back(FlagEnd);
    end
  endtask

  task automatic run_random(input int n_items);
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < n_items) begin
      add_random_frame();
      send_line();
    end
  endtask

  initial begin
    int cycle;
    int mode;
    int mode_left;
    int hold_left;
    cycle = 0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle % 700 == 350) hold_left = $urandom_range(60, 120);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= 1'($urandom_range(0, 1));
          default: res_bus.ready <= (cycle % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 8'h00;
    rx_bus.valid <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    burst_left = 0;
    items_sent = 0;
    cur_version = VersionReset;
    version_plan[0] = 8'd253;
    version_plan[1] = 8'd2;
    version_plan[2] = 8'($urandom_range(3, 252));
    version_plan[3] = 8'd128;
    version_plan[4] = VersionReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(200);
    foreach (version_plan[i]) begin
      wait_idle();
      write_version(version_plan[i]);
      run_random(200);
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
